### hdl/tps_pkg.sv
package tps_pkg;

   // Request codes carried in req_type.
   localparam logic [2:0] OP_CLEAR   = 3'd0;
   localparam logic [2:0] OP_APPEND  = 3'd1;
   localparam logic [2:0] OP_BUILD   = 3'd2;
   localparam logic [2:0] OP_SAMPLE  = 3'd3;
   localparam logic [2:0] OP_DENSITY = 3'd4;

   // Status codes returned with every result item.
   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_FEW     = 3'd1;
   localparam logic [2:0] STAT_FULL    = 3'd2;
   localparam logic [2:0] STAT_UNBUILT = 3'd3;
   localparam logic [2:0] STAT_ZERO    = 3'd4;

   // Fixed point widths of the table entries, the product split, the quotient and step count.
   localparam int CHARGE_W  = 16;
   localparam int DENSITY_W = 16;
   localparam int SPLIT_W   = 20;
   localparam int QUO_W     = 32;
   localparam int STEP_W    = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_SCAN,
      ST_EVAL,
      ST_PROD_A,
      ST_PROD_B,
      ST_DIV_SET,
      ST_DIV_RUN,
      ST_DONE
   } state_type;

   // Divider control and status.
   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
   } div_stat_type;

endpackage

### hdl/tps_req_if.sv
interface tps_req_if #(parameter int VALUE_BITS = 16) ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            req_type;
   logic [15:0]           charge_point;
   logic [15:0]           density_point;
   logic [VALUE_BITS-1:0] uniform_value;
   logic [15:0]           query_charge;

   modport source(output valid, req_type, charge_point, density_point, uniform_value,
                  query_charge, input ready);
   modport sink(input valid, req_type, charge_point, density_point, uniform_value,
                query_charge, output ready);
endinterface

### hdl/tps_rsp_if.sv
interface tps_rsp_if #(parameter int COUNT_W = 7) ();
   logic               valid;
   logic               ready;
   logic [15:0]        sampled_charge;
   logic [31:0]        density_value;
   logic [COUNT_W-1:0] points_held;
   logic [2:0]         status;

   modport source(output valid, sampled_charge, density_value, points_held, status,
                  input ready);
   modport sink(input valid, sampled_charge, density_value, points_held, status,
                output ready);
endinterface

### hdl/tabulated_pdf_sampler_core.sv
// Tabulated density sampler by piecewise-linear inverse transform.
// Requests enter on req_ch and each gives exactly one result item on rsp_ch.
// Clear and append do their work as the request is taken. Build rotates the chain
// of point cells once. A draw scales the uniform value by the area, rotates the
// chain to find the segment, then divides with the shared divider. A density
// query also rotates the chain and takes 32 quotient bits from the divider.
// One request is worked on at a time; a new item is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// When the receiver stalls, the result holds in the output register and the
// next finished request waits until it is taken.
// Reset empties the table (count, area and built flag go to zero); the point
// cells themselves are not cleared, no clearing pass is needed.
module tabulated_pdf_sampler_core #(
   parameter int TABLE_POINTS = 64,
   parameter int VALUE_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   tps_req_if.sink    req_ch,
   tps_rsp_if.source  rsp_ch
);

   localparam int IDX_W  = $clog2(TABLE_POINTS);
   localparam int CNT_W  = $clog2(TABLE_POINTS + 1);
   localparam int AREA_W = 34 + IDX_W;
   localparam int HI_W   = AREA_W - tps_pkg::SPLIT_W;
   localparam int OPA_W  = (VALUE_BITS > 16) ? VALUE_BITS : 16;
   localparam int OPB_W  = (HI_W > tps_pkg::SPLIT_W) ? HI_W : tps_pkg::SPLIT_W;
   localparam int PRD_W  = OPA_W + OPB_W;
   localparam int DIV_W  = AREA_W + 16;
   localparam int TGT_W  = VALUE_BITS + AREA_W;
   localparam int QW     = tps_pkg::CHARGE_W;

   // Point chain
   logic [QW-1:0]     cq [TABLE_POINTS];
   logic [15:0]       cd [TABLE_POINTS];
   logic [AREA_W-1:0] cc [TABLE_POINTS];
   logic [AREA_W-1:0] wrap_c;
   logic              shift_en;
   logic              load_en;

   tps_pkg::state_type state_ff, state_in;

   logic [2:0]            op_ff, op_in;
   logic [VALUE_BITS-1:0] uq_ff, uq_in;
   logic [QW-1:0]         qq_ff, qq_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [AREA_W-1:0]     area_ff, area_in;
   logic                  built_ff, built_in;
   logic [AREA_W-1:0]     acc_ff, acc_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [QW-1:0]         pq_ff, pq_in;
   logic [15:0]           pd_ff, pd_in;
   logic [AREA_W-1:0]     pc_ff, pc_in;
   logic [AREA_W-1:0]     target_ff, target_in;
   logic                  fnd_ff, fnd_in;
   logic                  below_ff, below_in;
   logic [QW-1:0]         lo_ff, lo_in;
   logic [15:0]           dq_ff, dq_in;
   logic [AREA_W-1:0]     off_ff, off_in;
   logic [AREA_W-1:0]     gap_ff, gap_in;
   logic [15:0]           da_ff, da_in;
   logic [15:0]           diff_ff, diff_in;
   logic                  neg_ff, neg_in;
   logic                  flat_ff, flat_in;
   logic [QW-1:0]         last_ff, last_in;
   logic [PRD_W-1:0]      pa_ff, pa_in;
   logic [PRD_W-1:0]      pb_ff, pb_in;
   logic [PRD_W-1:0]      mc_ff, mc_in;
   logic [PRD_W-1:0]      md_ff, md_in;
   logic [DIV_W-1:0]      num_ff, num_in;
   logic [DIV_W-1:0]      den_ff, den_in;
   logic [QW-1:0]         rs_ff, rs_in;
   logic [31:0]           rd_ff, rd_in;
   logic [2:0]            rt_ff, rt_in;
   logic                  ov_ff, ov_in;
   logic [QW-1:0]         os_ff, os_in;
   logic [31:0]           od_ff, od_in;
   logic [CNT_W-1:0]      oc_ff, oc_in;
   logic [2:0]            ot_ff, ot_in;

   logic                  req_fire;
   logic                  out_free;
   logic [2:0]            chk;
   logic                  full;
   logic                  scan_last;
   logic                  seg_ok;
   logic [QW-1:0]         seg_dq;
   logic [AREA_W-1:0]     term;
   logic [15:0]           dqm;
   logic                  sat;
   logic [DIV_W-1:0]      div_rem;
   logic [31:0]           div_low;
   logic [DIV_W-1:0]      div_dvs;
   logic [31:0]           quo;
   tps_pkg::div_ctrl_type div_ctrl;
   tps_pkg::div_stat_type div_stat;

   // Chain of point cells; cell 0 is the head, its point wraps to the tail.
   for (genvar k = 0; k < TABLE_POINTS; k++) begin : g_cell
      logic [QW-1:0]     nq;
      logic [15:0]       nd;
      logic [AREA_W-1:0] nc;
      if (k == TABLE_POINTS - 1) begin : g_tail
         assign nq = cq[0];
         assign nd = cd[0];
         assign nc = wrap_c;
      end else begin : g_mid
         assign nq = cq[k+1];
         assign nd = cd[k+1];
         assign nc = cc[k+1];
      end
      tps_cell #(.AREA_W(AREA_W)) u_cell (
         .clock (clock),
         .shift (shift_en),
         .load  (load_en && (cnt_ff[IDX_W-1:0] == IDX_W'(k))),
         .nb_q  (nq),
         .nb_d  (nd),
         .nb_c  (nc),
         .wr_q  (req_ch.charge_point),
         .wr_d  (req_ch.density_point),
         .q     (cq[k]),
         .d     (cd[k]),
         .c     (cc[k])
      );
   end

   tps_divider #(.DIV_W(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .rem_init (div_rem),
      .low_init (div_low),
      .divisor  (div_dvs),
      .stat     (div_stat),
      .quotient (quo)
   );

   // Common status terms.
   always_comb begin
      full     = cnt_ff >= CNT_W'(TABLE_POINTS);
      out_free = !ov_ff || rsp_ch.ready;
      req_fire = req_ch.valid && req_ch.ready;
      if (cnt_ff < CNT_W'(2)) begin
         chk = tps_pkg::STAT_FEW;
      end else if (!built_ff) begin
         chk = tps_pkg::STAT_UNBUILT;
      end else if (area_ff == '0) begin
         chk = tps_pkg::STAT_ZERO;
      end else begin
         chk = tps_pkg::STAT_OK;
      end
      scan_last = idx_ff == IDX_W'(TABLE_POINTS - 1);
      seg_ok    = (idx_ff != '0) && (CNT_W'(idx_ff) < cnt_ff);
      seg_dq    = (cq[0] > pq_ff) ? cq[0] - pq_ff : '0;
      term      = AREA_W'(seg_dq) * (AREA_W'(pd_ff) + AREA_W'(cd[0]));
      dqm       = flat_ff ? 16'd1 : dq_ff;
      sat       = {3'b000, num_ff} >= {den_ff, 3'b000};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tps_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.req_type)
                  tps_pkg::OP_BUILD:
                     state_in = (cnt_ff < CNT_W'(2)) ? tps_pkg::ST_DONE : tps_pkg::ST_SCAN;
                  tps_pkg::OP_SAMPLE:
                     state_in = (chk != tps_pkg::STAT_OK) ? tps_pkg::ST_DONE
                                                          : tps_pkg::ST_MUL_A;
                  tps_pkg::OP_DENSITY:
                     state_in = (chk != tps_pkg::STAT_OK) ? tps_pkg::ST_DONE
                                                          : tps_pkg::ST_SCAN;
                  default:
                     state_in = tps_pkg::ST_DONE;
               endcase
            end
         end
         tps_pkg::ST_MUL_A: state_in = tps_pkg::ST_MUL_B;
         tps_pkg::ST_MUL_B: state_in = tps_pkg::ST_SCAN;
         tps_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = tps_pkg::ST_EVAL;
            end
         end
         tps_pkg::ST_EVAL: begin
            if (op_ff == tps_pkg::OP_SAMPLE) begin
               state_in = (!fnd_ff || gap_ff == '0) ? tps_pkg::ST_DONE : tps_pkg::ST_PROD_A;
            end else if (op_ff == tps_pkg::OP_DENSITY) begin
               state_in = (below_ff || !fnd_ff) ? tps_pkg::ST_DONE : tps_pkg::ST_PROD_A;
            end else begin
               state_in = tps_pkg::ST_DONE;
            end
         end
         tps_pkg::ST_PROD_A: state_in = tps_pkg::ST_PROD_B;
         tps_pkg::ST_PROD_B: state_in = tps_pkg::ST_DIV_SET;
         tps_pkg::ST_DIV_SET: begin
            if (op_ff == tps_pkg::OP_DENSITY && sat) begin
               state_in = tps_pkg::ST_DONE;
            end else begin
               state_in = tps_pkg::ST_DIV_RUN;
            end
         end
         tps_pkg::ST_DIV_RUN: begin
            if (!div_stat.busy) begin
               state_in = tps_pkg::ST_DONE;
            end
         end
         tps_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tps_pkg::ST_IDLE;
            end
         end
         default: state_in = tps_pkg::ST_IDLE;
      endcase
   end

   // Control outputs decoded from the state.
   always_comb begin
      req_ch.ready   = state_ff == tps_pkg::ST_IDLE;
      shift_en       = state_ff == tps_pkg::ST_SCAN;
      load_en        = req_ch.valid && (state_ff == tps_pkg::ST_IDLE) &&
                       (req_ch.req_type == tps_pkg::OP_APPEND) && !full;
      div_ctrl.start = (state_ff == tps_pkg::ST_DIV_SET) &&
                       !(op_ff == tps_pkg::OP_DENSITY && sat);
      div_ctrl.steps = (op_ff == tps_pkg::OP_DENSITY) ? tps_pkg::STEP_W'(32)
                                                      : tps_pkg::STEP_W'(16);
      if (op_ff == tps_pkg::OP_DENSITY) begin
         div_rem = DIV_W'(num_ff >> 3);
         div_low = {num_ff[2:0], 29'd0};
         div_dvs = den_ff;
      end else begin
         div_rem = DIV_W'(num_ff >> 16);
         div_low = {num_ff[15:0], 16'd0};
         div_dvs = DIV_W'(gap_ff);
      end
   end

   // Cumulative area written back into the point leaving the head.
   always_comb begin
      wrap_c = cc[0];
      if (op_ff == tps_pkg::OP_BUILD) begin
         if (idx_ff == '0) begin
            wrap_c = '0;
         end else if (seg_ok) begin
            wrap_c = acc_ff + term;
         end
      end
   end

   // Datapath next values.
   always_comb begin
      op_in     = op_ff;
      uq_in     = uq_ff;
      qq_in     = qq_ff;
      cnt_in    = cnt_ff;
      area_in   = area_ff;
      built_in  = built_ff;
      acc_in    = acc_ff;
      idx_in    = idx_ff;
      pq_in     = pq_ff;
      pd_in     = pd_ff;
      pc_in     = pc_ff;
      target_in = target_ff;
      fnd_in    = fnd_ff;
      below_in  = below_ff;
      lo_in     = lo_ff;
      dq_in     = dq_ff;
      off_in    = off_ff;
      gap_in    = gap_ff;
      da_in     = da_ff;
      diff_in   = diff_ff;
      neg_in    = neg_ff;
      flat_in   = flat_ff;
      last_in   = last_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      mc_in     = mc_ff;
      md_in     = md_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rs_in     = rs_ff;
      rd_in     = rd_ff;
      rt_in     = rt_ff;
      ov_in     = ov_ff && !rsp_ch.ready;
      os_in     = os_ff;
      od_in     = od_ff;
      oc_in     = oc_ff;
      ot_in     = ot_ff;

      case (state_ff)
         // Take a request and do the single-cycle parts of it.
         tps_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_ch.req_type;
               uq_in    = req_ch.uniform_value;
               qq_in    = req_ch.query_charge;
               rs_in    = '0;
               rd_in    = '0;
               rt_in    = tps_pkg::STAT_OK;
               idx_in   = '0;
               acc_in   = '0;
               fnd_in   = 1'b0;
               below_in = 1'b0;
               case (req_ch.req_type)
                  tps_pkg::OP_CLEAR: begin
                     cnt_in   = '0;
                     area_in  = '0;
                     built_in = 1'b0;
                  end
                  tps_pkg::OP_APPEND: begin
                     if (full) begin
                        rt_in = tps_pkg::STAT_FULL;
                     end else begin
                        cnt_in   = cnt_ff + CNT_W'(1);
                        built_in = 1'b0;
                     end
                  end
                  tps_pkg::OP_BUILD: begin
                     if (cnt_ff < CNT_W'(2)) begin
                        rt_in = tps_pkg::STAT_FEW;
                     end
                  end
                  tps_pkg::OP_SAMPLE, tps_pkg::OP_DENSITY: begin
                     rt_in = chk;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Scaled draw as two partial products of the area.
         tps_pkg::ST_MUL_A: begin
            pa_in = PRD_W'(uq_ff) * PRD_W'(area_ff[tps_pkg::SPLIT_W-1:0]);
            pb_in = PRD_W'(uq_ff) * PRD_W'(area_ff[AREA_W-1:tps_pkg::SPLIT_W]);
         end
         tps_pkg::ST_MUL_B: begin
            target_in = AREA_W'(((TGT_W'(pb_ff) << tps_pkg::SPLIT_W) + TGT_W'(pa_ff))
                                >> VALUE_BITS);
         end
         // One point passes the head each cycle.
         tps_pkg::ST_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            pq_in  = cq[0];
            pd_in  = cd[0];
            pc_in  = cc[0];
            if (CNT_W'(idx_ff) == cnt_ff - CNT_W'(1)) begin
               last_in = cq[0];
            end
            case (op_ff)
               tps_pkg::OP_BUILD: begin
                  if (seg_ok) begin
                     acc_in = acc_ff + term;
                  end
               end
               tps_pkg::OP_SAMPLE: begin
                  if (seg_ok && !fnd_ff && target_ff <= cc[0]) begin
                     fnd_in = 1'b1;
                     gap_in = cc[0] - pc_ff;
                     lo_in  = pq_ff;
                     dq_in  = seg_dq;
                     off_in = (target_ff > pc_ff) ? target_ff - pc_ff : '0;
                  end
               end
               tps_pkg::OP_DENSITY: begin
                  if (idx_ff == '0 && qq_ff < cq[0]) begin
                     below_in = 1'b1;
                  end
                  if (seg_ok && !fnd_ff && qq_ff <= cq[0]) begin
                     fnd_in  = 1'b1;
                     lo_in   = pq_ff;
                     dq_in   = seg_dq;
                     flat_in = !(cq[0] > pq_ff);
                     off_in  = (qq_ff > pq_ff) ? AREA_W'(qq_ff - pq_ff) : '0;
                     da_in   = pd_ff;
                     neg_in  = cd[0] < pd_ff;
                     diff_in = (cd[0] >= pd_ff) ? cd[0] - pd_ff : pd_ff - cd[0];
                  end
               end
               default: begin
               end
            endcase
         end
         // Close the pass over the chain.
         tps_pkg::ST_EVAL: begin
            if (op_ff == tps_pkg::OP_BUILD) begin
               area_in  = acc_ff;
               built_in = 1'b1;
               rt_in    = (acc_ff == '0) ? tps_pkg::STAT_ZERO : tps_pkg::STAT_OK;
            end else if (op_ff == tps_pkg::OP_SAMPLE) begin
               if (!fnd_ff) begin
                  rs_in = last_ff;
               end else if (gap_ff == '0) begin
                  rs_in = lo_ff;
               end
            end
         end
         // Numerator and denominator products.
         tps_pkg::ST_PROD_A: begin
            if (op_ff == tps_pkg::OP_SAMPLE) begin
               pa_in = PRD_W'(off_ff[tps_pkg::SPLIT_W-1:0]) * PRD_W'(dq_ff);
               pb_in = PRD_W'(off_ff[AREA_W-1:tps_pkg::SPLIT_W]) * PRD_W'(dq_ff);
            end else begin
               pa_in = PRD_W'(da_ff) * PRD_W'(dqm);
               pb_in = flat_ff ? '0 : PRD_W'(off_ff[15:0]) * PRD_W'(diff_ff);
               mc_in = PRD_W'(area_ff[tps_pkg::SPLIT_W-1:0]) * PRD_W'(dqm);
               md_in = PRD_W'(area_ff[AREA_W-1:tps_pkg::SPLIT_W]) * PRD_W'(dqm);
            end
         end
         tps_pkg::ST_PROD_B: begin
            if (op_ff == tps_pkg::OP_SAMPLE) begin
               num_in = (DIV_W'(pb_ff) << tps_pkg::SPLIT_W) + DIV_W'(pa_ff);
            end else begin
               num_in = neg_ff ? DIV_W'(pa_ff - pb_ff) : DIV_W'(pa_ff + pb_ff);
               den_in = (DIV_W'(md_ff) << tps_pkg::SPLIT_W) + DIV_W'(mc_ff);
            end
         end
         tps_pkg::ST_DIV_SET: begin
            if (op_ff == tps_pkg::OP_DENSITY && sat) begin
               rd_in = 32'hFFFF_FFFF;
            end
         end
         tps_pkg::ST_DIV_RUN: begin
            if (!div_stat.busy) begin
               if (op_ff == tps_pkg::OP_SAMPLE) begin
                  rs_in = lo_ff + quo[15:0];
               end else begin
                  rd_in = quo;
               end
            end
         end
         // Hand the result to the output register.
         tps_pkg::ST_DONE: begin
            if (out_free) begin
               ov_in = 1'b1;
               os_in = rs_ff;
               od_in = rd_ff;
               oc_in = cnt_ff;
               ot_in = rt_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tps_pkg::ST_IDLE;
         cnt_ff   <= '0;
         area_ff  <= '0;
         built_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         area_ff  <= area_in;
         built_ff <= built_in;
         ov_ff    <= ov_in;
      end
      op_ff     <= op_in;
      uq_ff     <= uq_in;
      qq_ff     <= qq_in;
      acc_ff    <= acc_in;
      idx_ff    <= idx_in;
      pq_ff     <= pq_in;
      pd_ff     <= pd_in;
      pc_ff     <= pc_in;
      target_ff <= target_in;
      fnd_ff    <= fnd_in;
      below_ff  <= below_in;
      lo_ff     <= lo_in;
      dq_ff     <= dq_in;
      off_ff    <= off_in;
      gap_ff    <= gap_in;
      da_ff     <= da_in;
      diff_ff   <= diff_in;
      neg_ff    <= neg_in;
      flat_ff   <= flat_in;
      last_ff   <= last_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      mc_ff     <= mc_in;
      md_ff     <= md_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rs_ff     <= rs_in;
      rd_ff     <= rd_in;
      rt_ff     <= rt_in;
      os_ff     <= os_in;
      od_ff     <= od_in;
      oc_ff     <= oc_in;
      ot_ff     <= ot_in;
   end

   assign rsp_ch.valid          = ov_ff;
   assign rsp_ch.sampled_charge = os_ff;
   assign rsp_ch.density_value  = od_ff;
   assign rsp_ch.points_held    = oc_ff;
   assign rsp_ch.status         = ot_ff;

endmodule

### hdl/tps_cell.sv
// One table point: charge, density and cumulative area.
// The point moves to its neighbor on shift, or takes an appended point on load.
module tps_cell #(
   parameter int AREA_W = 40
) (
   input  logic                             clock,
   input  logic                             shift,
   input  logic                             load,
   input  logic [tps_pkg::CHARGE_W-1:0]     nb_q,
   input  logic [tps_pkg::DENSITY_W-1:0]    nb_d,
   input  logic [AREA_W-1:0]                nb_c,
   input  logic [tps_pkg::CHARGE_W-1:0]     wr_q,
   input  logic [tps_pkg::DENSITY_W-1:0]    wr_d,
   output logic [tps_pkg::CHARGE_W-1:0]     q,
   output logic [tps_pkg::DENSITY_W-1:0]    d,
   output logic [AREA_W-1:0]                c
);

   logic [tps_pkg::CHARGE_W-1:0]  q_ff, q_in;
   logic [tps_pkg::DENSITY_W-1:0] d_ff, d_in;
   logic [AREA_W-1:0]             c_ff, c_in;

   // Shift has priority; the two never coincide.
   always_comb begin
      q_in = q_ff;
      d_in = d_ff;
      c_in = c_ff;
      if (shift) begin
         q_in = nb_q;
         d_in = nb_d;
         c_in = nb_c;
      end else if (load) begin
         q_in = wr_q;
         d_in = wr_d;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      d_ff <= d_in;
      c_ff <= c_in;
   end

   assign q = q_ff;
   assign d = d_ff;
   assign c = c_ff;

endmodule

### hdl/tps_divider.sv
// Restoring divider, one quotient bit per cycle.
// The remainder starts below the divisor; low bits are shifted in from the top.
module tps_divider #(
   parameter int DIV_W = 56
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tps_pkg::div_ctrl_type      ctrl,
   input  logic [DIV_W-1:0]           rem_init,
   input  logic [tps_pkg::QUO_W-1:0]  low_init,
   input  logic [DIV_W-1:0]           divisor,
   output tps_pkg::div_stat_type      stat,
   output logic [tps_pkg::QUO_W-1:0]  quotient
);

   logic [DIV_W-1:0]            rem_ff, rem_in;
   logic [DIV_W-1:0]            dvs_ff, dvs_in;
   logic [tps_pkg::QUO_W-1:0]   low_ff, low_in;
   logic [tps_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [tps_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic [DIV_W:0]              trial;
   logic                        fits;

   // One trial subtraction per cycle.
   always_comb begin
      trial   = {rem_ff, low_ff[tps_pkg::QUO_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.start) begin
         rem_in  = rem_init;
         dvs_in  = divisor;
         low_in  = low_init;
         quo_in  = '0;
         cnt_in  = ctrl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_W'(trial - {1'b0, dvs_ff}) : DIV_W'(trial);
         low_in  = {low_ff[tps_pkg::QUO_W-2:0], 1'b0};
         quo_in  = {quo_ff[tps_pkg::QUO_W-2:0], fits};
         cnt_in  = cnt_ff - tps_pkg::STEP_W'(1);
         busy_in = cnt_ff != tps_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign quotient  = quo_ff;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int NPTS = 64;
   localparam int WATCH_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tps_req_if #(.VALUE_BITS(16)) req_ch ();
   tps_rsp_if #(.COUNT_W(7)) rsp_ch ();

   tabulated_pdf_sampler_core #(.TABLE_POINTS(NPTS), .VALUE_BITS(16)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #5 clock = ~clock;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] cq;
      logic [15:0] dp;
      logic [15:0] uv;
      logic [15:0] qc;
   } req_item_type;

   typedef struct packed {
      logic [15:0] charge;
      logic [31:0] dens;
      logic [6:0]  held;
      logic [2:0]  stat;
   } rsp_item_type;

   req_item_type pending_q[$];
   rsp_item_type expected_q[$];

   // Predictor state mirrors the table of the block.
   logic [15:0] mdl_charge[NPTS];
   logic [15:0] mdl_dens[NPTS];
   logic [63:0] mdl_cum[NPTS];
   int unsigned mdl_count;
   logic [63:0] mdl_area;
   bit          mdl_built;

   int  errors = 0;
   int  n_sent = 0;
   int  n_got = 0;
   int  n_samples = 0;
   int  n_dens = 0;
   int  send_idle = 13;
   int  recv_idle = 45;
   int  watch = 0;

   function automatic logic [2:0] ready_status();
      if (mdl_count < 2) return tps_pkg::STAT_FEW;
      if (!mdl_built) return tps_pkg::STAT_UNBUILT;
      if (mdl_area == 0) return tps_pkg::STAT_ZERO;
      return tps_pkg::STAT_OK;
   endfunction

   function automatic logic [15:0] draw_charge(logic [15:0] u);
      logic [63:0] target, base, gap, lo, hi, dq, off;
      target = ({48'd0, u} * mdl_area) >> 16;
      for (int i = 1; i < mdl_count; i++) begin
         if (target <= mdl_cum[i]) begin
            base = mdl_cum[i-1];
            gap = mdl_cum[i] - base;
            lo = mdl_charge[i-1];
            hi = mdl_charge[i];
            dq = hi > lo ? hi - lo : 64'd0;
            off = target > base ? target - base : 64'd0;
            if (gap == 0) return lo[15:0];
            return 16'(lo + (off * dq) / gap);
         end
      end
      return mdl_charge[mdl_count-1];
   endfunction

   function automatic logic [31:0] eval_density(logic [15:0] q);
      logic [63:0] lo, hi, da, db, dq, off, num, den, val;
      if (q < mdl_charge[0]) return 32'd0;
      for (int i = 1; i < mdl_count; i++) begin
         if (q <= mdl_charge[i]) begin
            lo = mdl_charge[i-1];
            hi = mdl_charge[i];
            da = mdl_dens[i-1];
            db = mdl_dens[i];
            if (hi > lo) begin
               dq = hi - lo;
               off = q > lo ? q - lo : 64'd0;
               if (db >= da) num = da * dq + off * (db - da);
               else num = da * dq - off * (da - db);
            end else begin
               dq = 1;
               num = da;
            end
            den = dq * mdl_area;
            val = (num << 29) / den;
            return val > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : val[31:0];
         end
      end
      return 32'd0;
   endfunction

   // Works out the result of one accepted request and updates the table copy.
   function automatic rsp_item_type predict_result(req_item_type r);
      rsp_item_type e;
      logic [63:0] acc, lo, hi, dq;
      e = '0;
      case (r.op)
         tps_pkg::OP_CLEAR: begin
            mdl_count = 0;
            mdl_area = 0;
            mdl_built = 0;
         end
         tps_pkg::OP_APPEND: begin
            if (mdl_count >= NPTS) e.stat = tps_pkg::STAT_FULL;
            else begin
               mdl_charge[mdl_count] = r.cq;
               mdl_dens[mdl_count] = r.dp;
               mdl_count++;
               mdl_built = 0;
            end
         end
         tps_pkg::OP_BUILD: begin
            if (mdl_count < 2) e.stat = tps_pkg::STAT_FEW;
            else begin
               acc = 0;
               mdl_cum[0] = 0;
               for (int i = 1; i < mdl_count; i++) begin
                  lo = mdl_charge[i-1];
                  hi = mdl_charge[i];
                  dq = hi > lo ? hi - lo : 64'd0;
                  acc += dq * ({48'd0, mdl_dens[i-1]} + {48'd0, mdl_dens[i]});
                  mdl_cum[i] = acc;
               end
               mdl_area = acc;
               mdl_built = 1;
               e.stat = acc == 0 ? tps_pkg::STAT_ZERO : tps_pkg::STAT_OK;
            end
         end
         tps_pkg::OP_SAMPLE: begin
            e.stat = ready_status();
            if (e.stat == tps_pkg::STAT_OK) e.charge = draw_charge(r.uv);
         end
         tps_pkg::OP_DENSITY: begin
            e.stat = ready_status();
            if (e.stat == tps_pkg::STAT_OK) e.dens = eval_density(r.qc);
         end
         default: ;
      endcase
      e.held = 7'(mdl_count);
      return e;
   endfunction

   function automatic req_item_type mk(logic [2:0] op, logic [15:0] a, logic [15:0] b);
      req_item_type r;
      r.op = op;
      r.cq = a;
      r.dp = b;
      r.uv = a;
      r.qc = a;
      return r;
   endfunction

   // Driver: presents pending items, idling at random between them.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            expected_q.push_back(predict_result(req_item_type'({req_ch.req_type,
               req_ch.charge_point, req_ch.density_point, req_ch.uniform_value,
               req_ch.query_charge})));
            n_sent++;
         end
         if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_item_type r;
            r = pending_q.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.req_type <= r.op;
            req_ch.charge_point <= r.cq;
            req_ch.density_point <= r.dp;
            req_ch.uniform_value <= r.uv;
            req_ch.query_charge <= r.qc;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Monitor: checks every accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_item_type a, e;
            a = {rsp_ch.sampled_charge, rsp_ch.density_value, rsp_ch.points_held,
                 rsp_ch.status};
            n_got++;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, a);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (e.charge != a.charge) begin
                  $display("%0t: sampled_charge expected %h actual %h", $time, e.charge,
                           a.charge);
                  errors++;
               end
               if (e.dens != a.dens) begin
                  $display("%0t: density_value expected %h actual %h", $time, e.dens,
                           a.dens);
                  errors++;
               end
               if (e.held != a.held) begin
                  $display("%0t: points_held expected %0d actual %0d", $time, e.held,
                           a.held);
                  errors++;
               end
               if (e.stat != a.stat) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.stat, a.stat);
                  errors++;
               end
               if (e.stat == tps_pkg::STAT_OK && a.charge != 0) n_samples++;
               if (e.stat == tps_pkg::STAT_OK && a.dens != 0) n_dens++;
            end
         end
         rsp_ch.ready <= $urandom_range(99) >= recv_idle;
      end
   end

   // Watchdog on cycles with no accepted item on either side.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         watch <= 0;
      else
         watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
         $display("tabulated_pdf_sampler_core regression: fail");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = tps_pkg::OP_CLEAR;
      req_ch.charge_point = '0;
      req_ch.density_point = '0;
      req_ch.uniform_value = '0;
      req_ch.query_charge = '0;
      rsp_ch.ready = 1'b0;
      mdl_count = 0;
      mdl_area = 0;
      mdl_built = 0;
   end

   // Random table load, then draws, lookups and unknown request codes against it.
   task automatic queue_session(int npts, bit monotone, int nq);
      int q;
      pending_q.push_back(mk(tps_pkg::OP_CLEAR, 16'($urandom), 16'($urandom)));
      q = $urandom_range(2000);
      for (int i = 0; i < npts; i++) begin
         if (monotone) q = q + $urandom_range(65535 / (npts + 1));
         else q = $urandom_range(65535);
         if (q > 65535) q = 65535;
         pending_q.push_back(mk(tps_pkg::OP_APPEND, 16'(q),
            ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom)));
      end
      pending_q.push_back(mk(tps_pkg::OP_BUILD, 16'($urandom), 16'($urandom)));
      for (int i = 0; i < nq; i++) begin
         case ($urandom_range(9))
            0: pending_q.push_back(mk(3'($urandom_range(5, 7)), 16'($urandom),
                                      16'($urandom)));
            1, 2, 3, 4: pending_q.push_back(mk(tps_pkg::OP_SAMPLE, 16'($urandom),
                                               16'($urandom)));
            default: pending_q.push_back(mk(tps_pkg::OP_DENSITY, 16'($urandom),
                                            16'($urandom)));
         endcase
      end
   endtask

   task automatic wait_drain();
      while (pending_q.size() > 0 || req_ch.valid || expected_q.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, too few points, zero area, extremes.
      pending_q.push_back(mk(tps_pkg::OP_SAMPLE, 16'hFFFF, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_DENSITY, 16'h0, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_BUILD, 16'h0, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_APPEND, 16'h0000, 16'h0000));
      pending_q.push_back(mk(tps_pkg::OP_BUILD, 16'h0, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_APPEND, 16'h8000, 16'h0000));
      pending_q.push_back(mk(tps_pkg::OP_SAMPLE, 16'h1234, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_BUILD, 16'h0, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_SAMPLE, 16'h1234, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_APPEND, 16'h8000, 16'hFFFF));
      pending_q.push_back(mk(tps_pkg::OP_APPEND, 16'h4000, 16'hFFFF));
      pending_q.push_back(mk(tps_pkg::OP_APPEND, 16'hFFFF, 16'h0001));
      pending_q.push_back(mk(tps_pkg::OP_DENSITY, 16'h1000, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_BUILD, 16'h0, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_SAMPLE, 16'h0000, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_SAMPLE, 16'hFFFF, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_SAMPLE, 16'h8000, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_DENSITY, 16'h8000, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_DENSITY, 16'hFFFF, 16'h0));
      pending_q.push_back(mk(tps_pkg::OP_DENSITY, 16'h6000, 16'h0));
      pending_q.push_back(mk(3'd7, 16'hFFFF, 16'hFFFF));
      pending_q.push_back(mk(3'd5, 16'h0, 16'h0));
      wait_drain();

      // Full table, then an append past the end.
      queue_session(NPTS, 1, 6);
      pending_q.push_back(mk(tps_pkg::OP_APPEND, 16'hFFFF, 16'hFFFF));
      pending_q.push_back(mk(tps_pkg::OP_SAMPLE, 16'hFFFF, 16'h0));
      wait_drain();

      // Random sessions across three idling phases, mostly small tables.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = ph == 0 ? 13 : (ph == 1 ? 45 : 0);
         recv_idle = ph == 0 ? 45 : (ph == 1 ? 13 : 0);
         for (int s = 0; s < 6; s++)
            queue_session($urandom_range(1, 10), $urandom_range(4) != 0,
                          $urandom_range(8, 16));
         wait_drain();
      end

      $display("Sent %0d requests, checked %0d results (%0d nonzero draws, %0d densities).",
               n_sent, n_got, n_samples, n_dens);
      if (errors == 0 && expected_q.size() == 0)
         $display("tabulated_pdf_sampler_core regression: pass");
      else
         $display("tabulated_pdf_sampler_core regression: fail");
      $finish;
   end

endmodule
